@@ rtl/hsvrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared constants and types for the HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

    // Default number of fraction bits; 1 << FRAC_BITS stands for 1.0.
    localparam int FRAC_BITS_DEF = 16;

    // Hue sector codes (hue * 6, integer part).
    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;

    // Per-stage load enables from the pipeline control to the datapath.
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } t_pipe_ctrl;

endpackage

`default_nettype wire

@@ rtl/hsvrgb_hsv_if.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_hsv_if
// Valid/ready channel carrying one HSV color per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvrgb_hsv_if #(
    parameter int W = hsvrgb_pkg::FRAC_BITS_DEF + 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] hue;
    logic [W-1:0] saturation;
    logic [W-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/hsvrgb_rgb_if.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_rgb_if
// Valid/ready channel carrying one RGB color per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvrgb_rgb_if #(
    parameter int W = hsvrgb_pkg::FRAC_BITS_DEF + 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] red;
    logic [W-1:0] green;
    logic [W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

@@ rtl/hsvrgb_core.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_core
// Four-stage datapath: sector split, s*f products, v products, routing.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_core #(
    parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire hsvrgb_pkg::t_pipe_ctrl  i_ctrl,
    input  wire logic [FRAC_BITS:0]      i_hue,
    input  wire logic [FRAC_BITS:0]      i_saturation,
    input  wire logic [FRAC_BITS:0]      i_brightness,
    output logic      [FRAC_BITS:0]      o_red,
    output logic      [FRAC_BITS:0]      o_green,
    output logic      [FRAC_BITS:0]      o_blue
);
    import hsvrgb_pkg::*;

    localparam int FB = FRAC_BITS;
    localparam int W  = FB + 1;
    localparam int HW = FB + 3;
    localparam logic [W-1:0] ONE = W'(1) << FB;

    // ---------------- stage 1: clamp, wrap, hue*6 ----------------
    logic [W-1:0]  n_s1_sat, n_s1_val;
    logic [HW-1:0] h_ext, h6;
    logic [2:0]    r_s1_sec;
    logic [FB-1:0] r_s1_f;
    logic [W-1:0]  r_s1_sat, r_s1_val;

    always_comb begin
        n_s1_sat = (i_saturation > ONE) ? ONE : i_saturation;
        n_s1_val = (i_brightness > ONE) ? ONE : i_brightness;
        // a full turn or more wraps to zero
        h_ext    = i_hue[FB] ? '0 : HW'(i_hue[FB-1:0]);
        h6       = (h_ext << 2) + (h_ext << 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en1) begin
            r_s1_sec <= h6[HW-1:FB];
            r_s1_f   <= h6[FB-1:0];
            r_s1_sat <= n_s1_sat;
            r_s1_val <= n_s1_val;
        end
    end

    // ---------------- stage 2: s*f, s*(1-f), 1-s ----------------
    logic [W-1:0]   one_m_f;
    logic [2*W-1:0] prod_sf, prod_sg;
    logic [W-1:0]   n_s2_aq, n_s2_at, n_s2_ap;
    logic [2:0]     r_s2_sec;
    logic [W-1:0]   r_s2_val, r_s2_aq, r_s2_at, r_s2_ap;

    always_comb begin
        one_m_f = ONE - W'(r_s1_f);
        prod_sf = (2*W)'(r_s1_sat) * (2*W)'(r_s1_f);
        prod_sg = (2*W)'(r_s1_sat) * (2*W)'(one_m_f);
        n_s2_aq = ONE - prod_sf[FB +: W];
        n_s2_at = ONE - prod_sg[FB +: W];
        n_s2_ap = ONE - r_s1_sat;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en2) begin
            r_s2_sec <= r_s1_sec;
            r_s2_val <= r_s1_val;
            r_s2_aq  <= n_s2_aq;
            r_s2_at  <= n_s2_at;
            r_s2_ap  <= n_s2_ap;
        end
    end

    // ---------------- stage 3: p, q, t ----------------
    logic [2*W-1:0] prod_p, prod_q, prod_t;
    logic [2:0]     r_s3_sec;
    logic [W-1:0]   r_s3_val, r_s3_p, r_s3_q, r_s3_t;

    always_comb begin
        prod_p = (2*W)'(r_s2_val) * (2*W)'(r_s2_ap);
        prod_q = (2*W)'(r_s2_val) * (2*W)'(r_s2_aq);
        prod_t = (2*W)'(r_s2_val) * (2*W)'(r_s2_at);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en3) begin
            r_s3_sec <= r_s2_sec;
            r_s3_val <= r_s2_val;
            r_s3_p   <= prod_p[FB +: W];
            r_s3_q   <= prod_q[FB +: W];
            r_s3_t   <= prod_t[FB +: W];
        end
    end

    // ---------------- stage 4: sector routing ----------------
    logic [W-1:0] n_red, n_green, n_blue;
    logic [W-1:0] r_red, r_green, r_blue;

    always_comb begin
        case (r_s3_sec)
            SEC_0: begin
                n_red = r_s3_val; n_green = r_s3_t;   n_blue = r_s3_p;
            end
            SEC_1: begin
                n_red = r_s3_q;   n_green = r_s3_val; n_blue = r_s3_p;
            end
            SEC_2: begin
                n_red = r_s3_p;   n_green = r_s3_val; n_blue = r_s3_t;
            end
            SEC_3: begin
                n_red = r_s3_p;   n_green = r_s3_q;   n_blue = r_s3_val;
            end
            SEC_4: begin
                n_red = r_s3_t;   n_green = r_s3_p;   n_blue = r_s3_val;
            end
            default: begin
                // sector five
                n_red = r_s3_val; n_green = r_s3_p;   n_blue = r_s3_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en4) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire

@@ rtl/hsv_to_rgb_converter_top.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// HSV to RGB color conversion, fixed point, one color per clock while the receiver keeps up.
//
// Input channel i_hsv carries hue, saturation and brightness; output channel
// o_rgb carries red, green and blue. All fields are FRAC_BITS+1 bits wide,
// unsigned, with 1 << FRAC_BITS standing for 1.0. Hue of a full turn wraps to
// zero; saturation and brightness above 1.0 clip to 1.0.
// Each channel moves one transaction at an edge where valid and ready are high.
// Throughput: one transaction per cycle while the receiver keeps up. Pipeline: four register
// stages (hue split, s*f products, v products, sector routing); a result is
// offered once its input transaction has passed through all four of them.
// When the receiver stalls, each stage holds and keeps loading while it still
// has a bubble, so input is taken until all four stages are full.
// Synchronous active-low reset empties the pipeline; no results are offered
// until new input arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_top #(
    parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    hsvrgb_hsv_if.sink   i_hsv,
    hsvrgb_rgb_if.source o_rgb
);
    import hsvrgb_pkg::*;

    t_pipe_ctrl ctrl;
    logic       r_v1, r_v2, r_v3, r_v4;

    // a stage loads when it is empty or its contents move on
    always_comb begin
        ctrl.en4 = !r_v4 || o_rgb.ready;
        ctrl.en3 = !r_v3 || ctrl.en4;
        ctrl.en2 = !r_v2 || ctrl.en3;
        ctrl.en1 = !r_v1 || ctrl.en2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ctrl.en1) r_v1 <= i_hsv.valid;
            if (ctrl.en2) r_v2 <= r_v1;
            if (ctrl.en3) r_v3 <= r_v2;
            if (ctrl.en4) r_v4 <= r_v3;
        end
    end

    assign i_hsv.ready = ctrl.en1;
    assign o_rgb.valid = r_v4;

    hsvrgb_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_ctrl       (ctrl),
        .i_hue        (i_hsv.hue),
        .i_saturation (i_hsv.saturation),
        .i_brightness (i_hsv.brightness),
        .o_red        (o_rgb.red),
        .o_green      (o_rgb.green),
        .o_blue       (o_rgb.blue)
    );

endmodule

`default_nettype wire

@@ verif/hsv_to_rgb_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsvrgb_checker
// Passive monitor for the HSV to RGB converter. Every accepted HSV
// transaction is converted by an independent fixed-point model and queued;
// every accepted RGB transaction is compared field by field with the oldest
// queued color. Mismatch and coverage counts go back to the testbench top.
// ----------------------------------------------------------------------------

module hsvrgb_checker #(
    parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hsvrgb_hsv_if      i_hsv,
    hsvrgb_rgb_if      i_rgb,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output int         o_wrapped,
    output int         o_clamped,
    output logic [5:0] o_sectors_seen
);
    import hsvrgb_pkg::*;

    localparam int          W         = FRAC_BITS + 1;
    localparam int          MAX_SHOWN = 10;
    localparam logic [63:0] ONE       = 64'd1 << FRAC_BITS;
    localparam logic [63:0] FRAC_MASK = ONE - 64'd1;

    typedef struct packed {
        logic [W-1:0] red;
        logic [W-1:0] green;
        logic [W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [W-1:0] hue;
        logic [W-1:0] saturation;
        logic [W-1:0] brightness;
        t_rgb         color;
    } t_color_rec;

    t_color_rec expected_colors[$];

    function automatic t_rgb predict_color(input logic [W-1:0] h_in, input logic [W-1:0] s_in,
                                           input logic [W-1:0] v_in, output logic [2:0] sector);
        logic [63:0] h, s, v, h6, f, p, q, t;
        t_rgb        c;
        h  = (64'(h_in) >= ONE) ? 64'd0 : 64'(h_in);
        s  = (64'(s_in) > ONE) ? ONE : 64'(s_in);
        v  = (64'(v_in) > ONE) ? ONE : 64'(v_in);
        h6 = h * 64'd6;
        sector = 3'(h6 >> FRAC_BITS);
        f  = h6 & FRAC_MASK;
        // each product truncates back to FRAC_BITS fraction bits
        p  = (v * (ONE - s)) >> FRAC_BITS;
        q  = (v * (ONE - ((s * f) >> FRAC_BITS))) >> FRAC_BITS;
        t  = (v * (ONE - ((s * (ONE - f)) >> FRAC_BITS))) >> FRAC_BITS;
        case (sector)
            SEC_0: begin c.red = W'(v); c.green = W'(t); c.blue = W'(p); end
            SEC_1: begin c.red = W'(q); c.green = W'(v); c.blue = W'(p); end
            SEC_2: begin c.red = W'(p); c.green = W'(v); c.blue = W'(t); end
            SEC_3: begin c.red = W'(p); c.green = W'(q); c.blue = W'(v); end
            SEC_4: begin c.red = W'(t); c.green = W'(p); c.blue = W'(v); end
            default: begin c.red = W'(v); c.green = W'(p); c.blue = W'(q); end
        endcase
        return c;
    endfunction

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_checked      = 0;
        o_wrapped      = 0;
        o_clamped      = 0;
        o_sectors_seen = '0;
    end

    always @(posedge i_clk) begin : monitor
        t_color_rec  rec;
        t_color_rec  want;
        t_rgb        got;
        logic [2:0]  sec;
        if (i_rst_n) begin
            if (i_hsv.valid && i_hsv.ready) begin
                rec.hue        = i_hsv.hue;
                rec.saturation = i_hsv.saturation;
                rec.brightness = i_hsv.brightness;
                rec.color      = predict_color(i_hsv.hue, i_hsv.saturation,
                                               i_hsv.brightness, sec);
                expected_colors.push_back(rec);
                if (sec < 3'd6)
                    o_sectors_seen[sec] = 1'b1;
                if (64'(i_hsv.hue) >= ONE)
                    o_wrapped++;
                if (64'(i_hsv.saturation) > ONE || 64'(i_hsv.brightness) > ONE)
                    o_clamped++;
            end
            if (i_rgb.valid && i_rgb.ready) begin
                got.red   = i_rgb.red;
                got.green = i_rgb.green;
                got.blue  = i_rgb.blue;
                if (expected_colors.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_SHOWN)
                        $display("%0t: unexpected RGB transaction r=%0d g=%0d b=%0d",
                                 $time, got.red, got.green, got.blue);
                end else begin
                    want = expected_colors.pop_front();
                    o_checked++;
                    if (got.red !== want.color.red || got.green !== want.color.green ||
                        got.blue !== want.color.blue) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_SHOWN)
                            $display({"%0t: mismatch for h=%0d s=%0d v=%0d: ",
                                      "expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d"},
                                     $time, want.hue, want.saturation, want.brightness,
                                     want.color.red, want.color.green, want.color.blue,
                                     got.red, got.green, got.blue);
                    end
                end
            end
            o_pending = expected_colors.size();
        end
    end

endmodule

@@ verif/tb_hsv_to_rgb_converter_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_top
// Drives HSV colors into the converter: directed corners (full-turn hue wrap,
// clamped saturation and brightness, sector edges), then random colors with
// random, bursty and absent idling on both channels and one long output
// stall that backs the pipeline up into its input. Checking is done by
// hsvrgb_checker; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_hsv_to_rgb_converter_top;

    localparam int           FRAC_BITS    = hsvrgb_pkg::FRAC_BITS_DEF;
    localparam int           W            = FRAC_BITS + 1;
    localparam logic [W-1:0] ONE          = W'(1) << FRAC_BITS;
    localparam logic [W-1:0] FIELD_MAX    = '1;
    localparam int           HOLD_CYCLES  = 300;
    localparam int           DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {PACE_NONE, PACE_RANDOM, PACE_BURSTY} t_pace;

    logic       clk;
    logic       rst_n;
    t_pace      pace;
    bit         rgb_hold_req;
    int         hold_count;
    int         sent;
    int         fail_count;
    int         pending_count;
    int         checked_count;
    int         wrapped_count;
    int         clamped_count;
    logic [5:0] sectors_seen;

    hsvrgb_hsv_if #(.W(W)) hsv_bus ();
    hsvrgb_rgb_if #(.W(W)) rgb_bus ();

    hsv_to_rgb_converter_top #(.FRAC_BITS(FRAC_BITS)) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_hsv   (hsv_bus),
        .o_rgb   (rgb_bus)
    );

    hsvrgb_checker #(.FRAC_BITS(FRAC_BITS)) u_color_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_hsv          (hsv_bus),
        .i_rgb          (rgb_bus),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count),
        .o_checked      (checked_count),
        .o_wrapped      (wrapped_count),
        .o_clamped      (clamped_count),
        .o_sectors_seen (sectors_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d colors still expected", pending_count);
        $display("tb_hsv_to_rgb_converter_top NOT OK");
        $finish;
    end

    function automatic int idle_cycles();
        case (pace)
            PACE_RANDOM: return $urandom_range(0, 16);
            PACE_BURSTY: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
            default:     return 0;
        endcase
    endfunction

    // mostly in range, with the corners and over-range values mixed in
    function automatic logic [W-1:0] rand_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONE;
            2:       return W'($urandom_range(int'(ONE) + 1, int'(FIELD_MAX)));
            3:       return ONE - W'(1);
            default: return W'($urandom_range(0, int'(ONE) - 1));
        endcase
    endfunction

    task automatic send_color(input logic [W-1:0] h, input logic [W-1:0] s,
                              input logic [W-1:0] v);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            hsv_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hsv_bus.valid      <= 1'b1;
        hsv_bus.hue        <= h;
        hsv_bus.saturation <= s;
        hsv_bus.brightness <= v;
        do @(posedge clk); while (!hsv_bus.ready);
        sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_color(rand_level(), rand_level(), rand_level());
    endtask

    // output side: random stall per transaction, or one long hold on request
    initial begin
        int stall;
        rgb_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (rgb_hold_req) begin
                rgb_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rgb_hold_req = 1'b0;
                hold_count++;
            end else begin
                stall = idle_cycles();
                if (stall > 0) begin
                    rgb_bus.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            rgb_bus.ready <= 1'b1;
            do @(posedge clk); while (!rgb_bus.valid);
        end
    end

    initial begin
        pace         = PACE_NONE;
        rgb_hold_req = 1'b0;
        hold_count   = 0;
        sent         = 0;
        rst_n              <= 1'b0;
        hsv_bus.valid      <= 1'b0;
        hsv_bus.hue        <= '0;
        hsv_bus.saturation <= '0;
        hsv_bus.brightness <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_color('0, ONE, ONE);
        send_color(ONE - W'(1), ONE, ONE);
        send_color(ONE, ONE, ONE);                  // full turn wraps to zero
        send_color(FIELD_MAX, FIELD_MAX, FIELD_MAX);
        send_color(ONE + W'(1), '0, FIELD_MAX);
        send_color(W'(20000), '0, W'(40000));       // grey
        send_color(W'(30000), ONE, '0);             // black
        for (int k = 0; k < 6; k++)
            send_color(W'(((2 * k + 1) * int'(ONE)) / 12), W'(16'hC000), W'(16'hE000));
        // first hue of each sector and the last hue of the one below
        for (int k = 1; k < 6; k++) begin
            send_color(W'((k * int'(ONE) + 5) / 6), ONE, W'(16'hF000));
            send_color(W'((k * int'(ONE) + 5) / 6 - 1), ONE, W'(16'hF000));
        end

        pace = PACE_RANDOM;
        send_random(300);

        // long output stall while the input keeps offering back to back
        pace         = PACE_NONE;
        rgb_hold_req = 1'b1;
        send_random(150);

        pace = PACE_BURSTY;
        send_random(300);
        pace = PACE_RANDOM;
        send_random(377);

        hsv_bus.valid <= 1'b0;
        do @(negedge clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d colors, checked %0d, %0d hue wraps, %0d clamped inputs",
                 sent, checked_count, wrapped_count, clamped_count);
        $display("sectors seen %b, long output stalls %0d, mismatches %0d",
                 sectors_seen, hold_count, fail_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_hsv_to_rgb_converter_top OK");
        end else begin
            $display("tb_hsv_to_rgb_converter_top NOT OK");
        end
        $finish;
    end

endmodule
